// File: src/dsm_pkg.sv
`default_nettype none

package dsm_pkg;

	localparam int STATE_W  = 6;
	localparam int LETTER_W = 8;

	// result queue: holds every end-of-string result that may be in flight
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = 2;
	localparam int RQ_CW    = 3;

	typedef enum logic [1:0] {
		OP_WR_TRANS = 2'd0,
		OP_WR_MARK  = 2'd1,
		OP_FEED     = 2'd2,
		OP_END      = 2'd3
	} op_t;

	typedef struct packed {
		logic               present;
		logic [STATE_W-1:0] next;
	} trans_entry_t;

	typedef struct packed {
		logic matched;
		logic hit_missing;
	} result_t;

endpackage

`default_nettype wire

// File: src/dfa_string_matcher_unit.sv
// Throughput: one item per cycle while item_ready is high, characters included;
//   a character's table read and the next character's address meet at the
//   transition RAM read register. An accepted end-of-string passes the s1 and s2
//   registers and the result queue before its result shows.
// Reset: arst_n clears control state, then a clearing pass writes every
//   transition entry and accepting mark to zero; item_ready stays low meanwhile.
`default_nettype none

module dfa_string_matcher_unit
	import dsm_pkg::*;
#(
	parameter int unsigned NUM_STATES    = 64,
	parameter int unsigned ALPHABET_SIZE = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration: start state
	input  wire logic                cfg_wr_en,
	input  wire logic [STATE_W-1:0]  cfg_wr_data,
	// item channel
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire logic [1:0]          operation,
	input  wire logic [STATE_W-1:0]  state_index,
	input  wire logic [LETTER_W-1:0] letter,
	input  wire logic [STATE_W-1:0]  next_state,
	input  wire logic                flag_value,
	// result channel
	output logic                     result_valid,
	input  wire logic                result_ready,
	output logic                     matched,
	output logic                     hit_missing
);

	localparam int SW     = $clog2(NUM_STATES);
	localparam int LW     = $clog2(ALPHABET_SIZE);
	localparam int TAW    = SW + LW;
	localparam int TE_W   = $bits(trans_entry_t);

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	logic [STATE_W-1:0] start_q;     // start state register
	logic [STATE_W-1:0] cur_q;       // automaton state after last retired item
	logic               instr_q;     // a string is in progress
	logic               rej_q;       // current string has hit a missing transition
	logic               clearing_q;  // table clearing pass running
	logic [TAW-1:0]     clr_cnt_q;
	logic [RQ_CW-1:0]   pend_q;      // ends accepted whose result is not yet transferred

	// ------------------------------------------------------------------
	// Pipeline: s1 = memory access, s2 = read data back, state update
	// ------------------------------------------------------------------
	logic                valid_s1;
	op_t                 op_s1;
	logic [STATE_W-1:0]  src_s1;
	logic [LETTER_W-1:0] letter_s1;
	logic [STATE_W-1:0]  dst_s1;
	logic                flag_s1;

	logic                valid_s2;
	op_t                 op_s2;
	logic                rej_s2;     // string already rejected when looked up
	logic                ok_s2;      // feed: lookup in range; end: state in range

	logic item_xfer;
	logic end_xfer;
	logic out_xfer;

	assign item_xfer = item_valid && item_ready;
	assign end_xfer  = item_xfer && (op_t'(operation) == OP_END);
	assign out_xfer  = result_valid && result_ready;

	// credit against the result queue, so the pipeline never has to stall
	assign item_ready = !clearing_q && (pend_q < RQ_CW'(RQ_DEPTH));

	// ------------------------------------------------------------------
	// s2: retire the item using the RAM read registers
	// ------------------------------------------------------------------
	trans_entry_t       trans_rd;
	logic               mark_rd;
	logic [STATE_W-1:0] cur_nx;
	logic               instr_nx;
	logic               rej_nx;
	logic               res_push;
	result_t            res;

	always_comb begin
		cur_nx   = cur_q;
		instr_nx = instr_q;
		rej_nx   = rej_q;
		res_push = 1'b0;
		res      = '0;
		if (valid_s2) begin
			case (op_s2)
				OP_FEED: begin
					// once rejected the state no longer matters
					instr_nx = 1'b1;
					rej_nx   = rej_s2 || !(ok_s2 && trans_rd.present);
					cur_nx   = trans_rd.next;
				end
				OP_END: begin
					instr_nx        = 1'b0;
					rej_nx          = 1'b0;
					res_push        = 1'b1;
					res.matched     = !rej_s2 && ok_s2 && mark_rd;
					res.hit_missing = rej_s2;
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// s1: address generation. The state seen here is the one s2 leaves
	// behind, forwarded straight from the read register.
	// ------------------------------------------------------------------
	logic [STATE_W-1:0] base_state;
	logic               rej_base;
	logic               base_ok;
	logic               letter_ok;
	logic               src_ok;

	logic               t_we;
	logic [TAW-1:0]     t_addr;
	trans_entry_t       t_wdata;
	logic               m_we;
	logic [SW-1:0]      m_addr;
	logic               m_wdata;

	assign base_state = instr_nx ? cur_nx : start_q;
	assign rej_base   = instr_nx && rej_nx;
	assign base_ok    = (32'(base_state) < NUM_STATES);
	assign letter_ok  = (32'(letter_s1) < ALPHABET_SIZE);
	assign src_ok     = (32'(src_s1) < NUM_STATES);

	always_comb begin
		t_we    = 1'b0;
		t_addr  = {SW'(base_state), LW'(letter_s1)};
		t_wdata = '0;
		m_we    = 1'b0;
		m_addr  = SW'(base_state);
		m_wdata = 1'b0;
		if (clearing_q) begin
			t_we   = 1'b1;
			t_addr = clr_cnt_q;
			m_we   = 1'b1;
			m_addr = clr_cnt_q[SW-1:0];
		end else if (valid_s1) begin
			case (op_s1)
				OP_WR_TRANS: begin
					if (src_ok && letter_ok) begin
						t_we            = 1'b1;
						t_addr          = {SW'(src_s1), LW'(letter_s1)};
						t_wdata.present = flag_s1;
						t_wdata.next    = dst_s1;
					end
				end
				OP_WR_MARK: begin
					if (src_ok) begin
						m_we    = 1'b1;
						m_addr  = SW'(src_s1);
						m_wdata = flag_s1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	dsm_ram #(
		.ADDR_W (TAW),
		.DATA_W (TE_W)
	) u_trans_ram (
		.clk   (clk),
		.we    (t_we),
		.addr  (t_addr),
		.wdata (t_wdata),
		.rdata (trans_rd)
	);

	dsm_ram #(
		.ADDR_W (SW),
		.DATA_W (1)
	) u_mark_ram (
		.clk   (clk),
		.we    (m_we),
		.addr  (m_addr),
		.wdata (m_wdata),
		.rdata (mark_rd)
	);

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			op_s1     <= op_t'(operation);
			src_s1    <= state_index;
			letter_s1 <= letter;
			dst_s1    <= next_state;
			flag_s1   <= flag_value;
		end
		op_s2  <= op_s1;
		rej_s2 <= rej_base;
		ok_s2  <= (op_s1 == OP_FEED) ? (base_ok && letter_ok) : base_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			start_q    <= '0;
			cur_q      <= '0;
			instr_q    <= 1'b0;
			rej_q      <= 1'b0;
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			pend_q     <= '0;
		end else begin
			valid_s1 <= item_xfer;
			valid_s2 <= valid_s1;
			cur_q    <= cur_nx;
			instr_q  <= instr_nx;
			rej_q    <= rej_nx;
			if (cfg_wr_en) begin
				start_q <= cfg_wr_data;
			end
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + TAW'(1);
				if (clr_cnt_q == {TAW{1'b1}}) begin
					clearing_q <= 1'b0;
				end
			end
			case ({end_xfer, out_xfer})
				2'b10:   pend_q <= pend_q + RQ_CW'(1);
				2'b01:   pend_q <= pend_q - RQ_CW'(1);
				default: pend_q <= pend_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result queue: parts the pipeline from the consumer
	// ------------------------------------------------------------------
	result_t res_out;

	dsm_result_queue u_result_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.pop       (result_ready),
		.out_valid (result_valid),
		.out_data  (res_out)
	);

	assign matched     = res_out.matched;
	assign hit_missing = res_out.hit_missing;

endmodule

`default_nettype wire

// File: src/dsm_ram.sv
`default_nettype none

module dsm_ram #(
	parameter int ADDR_W = 14,
	parameter int DATA_W = 7
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [DATA_W-1:0] wdata,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	// single port, read-first, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: src/dsm_result_queue.sv
`default_nettype none

module dsm_result_queue
	import dsm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	input  wire logic    pop,
	output logic         out_valid,
	output result_t      out_data
);

	result_t          buf_q [RQ_DEPTH];
	logic [RQ_AW-1:0] wr_ptr_q;
	logic [RQ_AW-1:0] rd_ptr_q;
	logic [RQ_CW-1:0] cnt_q;
	logic             do_pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = buf_q[rd_ptr_q];
	assign do_pop    = pop && out_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	// no overflow check: upstream credit keeps occupancy within depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + RQ_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + RQ_AW'(1);
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + RQ_CW'(1);
				2'b01:   cnt_q <= cnt_q - RQ_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/dsm_checker.sv
`default_nettype none

module dsm_checker
	import dsm_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_valid,
	input wire logic       item_ready,
	input wire logic [1:0] operation,
	input wire logic       result_valid,
	input wire logic       result_ready,
	input wire logic       matched,
	input wire logic       hit_missing
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable({matched, hit_missing}))
		else $error("result changed while stalled");

	// a rejected string never reports a match
	a_rej_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(matched && hit_missing))
		else $error("matched and hit_missing both set");

	// a fresh result follows an end-of-string transfer by the pipeline depth
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |->
			$past(item_valid && item_ready && (op_t'(operation) == OP_END), 3))
		else $error("result without a matching end-of-string");

endmodule

bind dfa_string_matcher_unit dsm_checker u_dsm_checker (.*);

`default_nettype wire
